/* rtl/cpts_pkg.sv */
// Shared types and constants of the counter priority task scheduler.
package cpts_pkg;

	localparam int CNT_W  = 10;
	localparam int PRIO_W = 8;
	localparam int TST_W  = 2;
	localparam int KIND_W = 2;
	localparam int TID_W  = 4;

	localparam logic [CNT_W-1:0]  CNT_MAX    = 10'd1023;
	localparam logic [TST_W-1:0]  ST_RUNNING = 2'd0;
	localparam logic [TST_W-1:0]  ST_ZOMBIE  = 2'd2;
	localparam logic [PRIO_W-1:0] PRIO_IDLE  = 8'd1;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK  = 2'd0,
		KIND_YIELD = 2'd1,
		KIND_ADD   = 2'd2,
		KIND_EXIT  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_TICK,
		OP_ZERO,
		OP_ADD,
		OP_CHARGE
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic              kill;
		logic [PRIO_W-1:0] prio;
		logic [CNT_W-1:0]  cnt;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_SCAN,
		SEQ_FINISH
	} seq_state_t;

endpackage

/* rtl/cpts_cell.sv */
// One task slot: counter, priority and state, plus one registered stage of the pick chain.
module cpts_cell #(
	parameter int MAX_TASKS = 16,
	parameter int IDX       = 0
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cpts_pkg::cell_cmd_t             cmd,
	input  logic [$clog2(MAX_TASKS)-1:0]    cur_idx,
	input  logic [$clog2(MAX_TASKS)-1:0]    tgt_idx,
	input  logic                            sc_any_in,
	input  logic [cpts_pkg::CNT_W-1:0]      sc_cnt_in,
	input  logic [$clog2(MAX_TASKS)-1:0]    sc_idx_in,
	output logic                            sc_any_out,
	output logic [cpts_pkg::CNT_W-1:0]      sc_cnt_out,
	output logic [$clog2(MAX_TASKS)-1:0]    sc_idx_out,
	output logic                            low
);
	import cpts_pkg::*;

	localparam int IW = $clog2(MAX_TASKS);
	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic              used_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PRIO_W-1:0] prio_q;
	logic [TST_W-1:0]  tst_q;
	logic              sc_any_q;
	logic [CNT_W-1:0]  sc_cnt_q;
	logic [IW-1:0]     sc_idx_q;

	logic              is_cur;
	logic              is_tgt;
	logic [CNT_W:0]    charge_sum;
	logic [CNT_W-1:0]  charge_val;
	logic              take;

	assign is_cur     = (cur_idx == MY_IDX);
	assign is_tgt     = (tgt_idx == MY_IDX);
	assign charge_sum = {2'b00, cnt_q[CNT_W-1:1]} + {{(CNT_W+1-PRIO_W){1'b0}}, prio_q};
	assign charge_val = charge_sum[CNT_W] ? CNT_MAX : charge_sum[CNT_W-1:0];
	assign low        = is_cur && (cnt_q <= CNT_W'(1));
	assign take       = used_q && (tst_q == ST_RUNNING) && (!sc_any_in || (cnt_q > sc_cnt_in));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= (IDX == 0);
			cnt_q  <= '0;
			prio_q <= (IDX == 0) ? PRIO_IDLE : '0;
			tst_q  <= ST_RUNNING;
		end else begin
			unique case (cmd.op)
				OP_TICK: begin
					if (is_cur && cnt_q != '0)
						cnt_q <= cnt_q - CNT_W'(1);
				end
				OP_ZERO: begin
					if (is_cur)
						cnt_q <= '0;
					if (cmd.kill && is_tgt)
						tst_q <= ST_ZOMBIE;
				end
				OP_ADD: begin
					if (is_tgt) begin
						used_q <= 1'b1;
						cnt_q  <= cmd.cnt;
						prio_q <= (cmd.prio == '0) ? PRIO_IDLE : cmd.prio;
						tst_q  <= ST_RUNNING;
					end
				end
				OP_CHARGE: begin
					if (used_q)
						cnt_q <= charge_val;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_any_q <= 1'b0;
		end else begin
			sc_any_q <= sc_any_in || take;
		end
	end

	always_ff @(posedge clk) begin
		sc_cnt_q <= take ? cnt_q : sc_cnt_in;
		sc_idx_q <= take ? MY_IDX : sc_idx_in;
	end

	assign sc_any_out = sc_any_q;
	assign sc_cnt_out = sc_cnt_q;
	assign sc_idx_out = sc_idx_q;

endmodule

/* rtl/cpts_ctrl.sv */
// Request sequencer: decodes requests, runs the pick and recharge passes, holds the result.
module cpts_ctrl #(
	parameter int MAX_TASKS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [cpts_pkg::KIND_W-1:0]         kind,
	input  logic [cpts_pkg::TID_W-1:0]          task_id,
	input  logic [cpts_pkg::PRIO_W-1:0]         new_priority,
	input  logic [cpts_pkg::CNT_W-1:0]          start_counter,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [cpts_pkg::TID_W-1:0]          current_task,
	output logic                                switched,
	output logic [cpts_pkg::TID_W-1:0]          assigned_id,
	output logic                                status,
	output cpts_pkg::cell_cmd_t                 cmd,
	output logic [$clog2(MAX_TASKS)-1:0]        cur_idx,
	output logic [$clog2(MAX_TASKS)-1:0]        tgt_idx,
	input  logic                                low,
	input  logic                                sc_any,
	input  logic [cpts_pkg::CNT_W-1:0]          sc_cnt,
	input  logic [$clog2(MAX_TASKS)-1:0]        sc_idx
);
	import cpts_pkg::*;

	localparam int IW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int XW = (CW > TID_W) ? CW : TID_W;
	localparam logic [CW-1:0] FULL = CW'(MAX_TASKS);

	seq_state_t state_q, state_d;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    scan_q;
	logic             pass_q;
	logic [IW-1:0]    running_q;
	logic [IW-1:0]    prev_q;
	logic [TID_W-1:0] assigned_q;
	logic             status_q;
	logic             out_valid_q;
	logic [TID_W-1:0] cur_task_q;
	logic             switched_q;
	logic [TID_W-1:0] out_assigned_q;
	logic             out_status_q;

	kind_t kind_k;
	logic  accept;
	logic  full;
	logic  tid_ok;
	logic  scan_done;
	logic  need_charge;
	logic  out_load;

	assign kind_k      = kind_t'(kind);
	assign accept      = in_valid && (state_q == SEQ_IDLE);
	assign full        = (count_q == FULL);
	assign tid_ok      = XW'(task_id) < XW'(count_q);
	assign scan_done   = (state_q == SEQ_SCAN) && (scan_q == CW'(MAX_TASKS));
	assign need_charge = scan_done && sc_any && (sc_cnt == '0) && !pass_q;
	assign out_load    = (state_q == SEQ_FINISH) && (!out_valid_q || !out_stall);
	assign in_stall    = (state_q != SEQ_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SEQ_IDLE: begin
				if (accept) begin
					unique case (kind_k)
						KIND_TICK:  state_d = low ? SEQ_SCAN : SEQ_FINISH;
						KIND_YIELD: state_d = SEQ_SCAN;
						KIND_ADD:   state_d = SEQ_FINISH;
						KIND_EXIT:  state_d = SEQ_SCAN;
						default:    state_d = SEQ_FINISH;
					endcase
				end
			end
			SEQ_SCAN: begin
				if (scan_done && !need_charge)
					state_d = SEQ_FINISH;
			end
			SEQ_FINISH: begin
				if (out_load)
					state_d = SEQ_IDLE;
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	// commands to the cell row
	always_comb begin
		cmd.op   = OP_NONE;
		cmd.kill = 1'b0;
		cmd.prio = new_priority;
		cmd.cnt  = start_counter;
		cur_idx  = running_q;
		tgt_idx  = (kind_k == KIND_ADD) ? IW'(count_q) : IW'(task_id);
		if (accept) begin
			unique case (kind_k)
				KIND_TICK:  cmd.op = OP_TICK;
				KIND_YIELD: cmd.op = OP_ZERO;
				KIND_ADD:   cmd.op = full ? OP_NONE : OP_ADD;
				KIND_EXIT: begin
					cmd.op   = OP_ZERO;
					cmd.kill = tid_ok;
				end
				default:    cmd.op = OP_NONE;
			endcase
		end else if (need_charge) begin
			cmd.op = OP_CHARGE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SEQ_IDLE;
			count_q     <= CW'(1);
			scan_q      <= '0;
			pass_q      <= 1'b0;
			running_q   <= '0;
			prev_q      <= '0;
			assigned_q  <= '0;
			status_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				prev_q     <= running_q;
				scan_q     <= '0;
				pass_q     <= 1'b0;
				assigned_q <= '0;
				status_q   <= 1'b0;
				if (kind_k == KIND_ADD) begin
					if (full) begin
						status_q <= 1'b1;
					end else begin
						assigned_q <= TID_W'(count_q);
						count_q    <= count_q + CW'(1);
					end
				end
			end else if (state_q == SEQ_SCAN) begin
				if (need_charge) begin
					scan_q <= '0;
					pass_q <= 1'b1;
				end else if (scan_done) begin
					running_q <= sc_any ? sc_idx : '0;
				end else begin
					scan_q <= scan_q + CW'(1);
				end
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			cur_task_q     <= TID_W'(running_q);
			switched_q     <= (running_q != prev_q);
			out_assigned_q <= assigned_q;
			out_status_q   <= status_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign current_task = cur_task_q;
	assign switched     = switched_q;
	assign assigned_id  = out_assigned_q;
	assign status       = out_status_q;

`ifndef SYNTHESIS
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_SCAN) |-> (scan_q <= CW'(MAX_TASKS)))
		else $error("pick pass ran past the end of the chain");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) && (count_q <= FULL))
		else $error("task count out of range");
	a_full_add: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind_k == KIND_ADD && full) |=> ($stable(count_q) && status_q))
		else $error("refused add changed the table");
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid && state_q == SEQ_IDLE))
		else $error("finished request did not reach the output");
`endif

endmodule

/* rtl/counter_priority_task_scheduler.sv */
// Counter priority task scheduler: sequencer plus a row of task cells forming the pick chain.
// Tick without expiry and add go straight from decode to the finish state; yield, exit and
// an expiring tick first run a pick pass, followed by a recharge and a second pick pass when
// the best counter is zero. The pick walks the cell chain one cell per cycle.
// One request at a time; a finished result waits in the output register while the next is taken.
// Reset: asynchronous, leaves only the idle task in slot 0, current task 0.
module counter_priority_task_scheduler #(
	parameter int MAX_TASKS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [cpts_pkg::KIND_W-1:0]  kind,
	input  logic [cpts_pkg::TID_W-1:0]   task_id,
	input  logic [cpts_pkg::PRIO_W-1:0]  new_priority,
	input  logic [cpts_pkg::CNT_W-1:0]   start_counter,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [cpts_pkg::TID_W-1:0]   current_task,
	output logic                         switched,
	output logic [cpts_pkg::TID_W-1:0]   assigned_id,
	output logic                         status
);
	import cpts_pkg::*;

	localparam int IW = $clog2(MAX_TASKS);

	cell_cmd_t        cmd;
	logic [IW-1:0]    cur_idx;
	logic [IW-1:0]    tgt_idx;
	logic             ch_any [MAX_TASKS+1];
	logic [CNT_W-1:0] ch_cnt [MAX_TASKS+1];
	logic [IW-1:0]    ch_idx [MAX_TASKS+1];
	logic [MAX_TASKS-1:0] low_vec;

	assign ch_any[0] = 1'b0;
	assign ch_cnt[0] = '0;
	assign ch_idx[0] = '0;

	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		cpts_cell #(
			.MAX_TASKS(MAX_TASKS),
			.IDX      (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.cur_idx   (cur_idx),
			.tgt_idx   (tgt_idx),
			.sc_any_in (ch_any[i]),
			.sc_cnt_in (ch_cnt[i]),
			.sc_idx_in (ch_idx[i]),
			.sc_any_out(ch_any[i+1]),
			.sc_cnt_out(ch_cnt[i+1]),
			.sc_idx_out(ch_idx[i+1]),
			.low       (low_vec[i])
		);
	end

	cpts_ctrl #(
		.MAX_TASKS(MAX_TASKS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.task_id      (task_id),
		.new_priority (new_priority),
		.start_counter(start_counter),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.current_task (current_task),
		.switched     (switched),
		.assigned_id  (assigned_id),
		.status       (status),
		.cmd          (cmd),
		.cur_idx      (cur_idx),
		.tgt_idx      (tgt_idx),
		.low          (|low_vec),
		.sc_any       (ch_any[MAX_TASKS]),
		.sc_cnt       (ch_cnt[MAX_TASKS]),
		.sc_idx       (ch_idx[MAX_TASKS])
	);

endmodule

/* verif/counter_priority_task_scheduler_chk.sv */
// Checker for the task scheduler: watches both channels, predicts each decision and compares.
module counter_priority_task_scheduler_chk #(
	parameter int MAX_TASKS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [cpts_pkg::KIND_W-1:0] kind,
	input  logic [cpts_pkg::TID_W-1:0]  task_id,
	input  logic [cpts_pkg::PRIO_W-1:0] new_priority,
	input  logic [cpts_pkg::CNT_W-1:0]  start_counter,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [cpts_pkg::TID_W-1:0]  current_task,
	input  logic                        switched,
	input  logic [cpts_pkg::TID_W-1:0]  assigned_id,
	input  logic                        status,
	output int                          mismatches,
	output int                          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import cpts_pkg::*;

	typedef struct packed {
		logic [TID_W-1:0] cur;
		logic             sw;
		logic [TID_W-1:0] aid;
		logic             full;
	} decision_t;

	logic [CNT_W-1:0]  slice_q [MAX_TASKS];
	logic [PRIO_W-1:0] prio_q  [MAX_TASKS];
	logic [TST_W-1:0]  state_q [MAX_TASKS];
	int                task_total;
	logic [TID_W-1:0]  cur_q;
	decision_t         decision_q [$];

	task automatic pick_best(output logic found, output logic [CNT_W-1:0] best,
			output logic [TID_W-1:0] idx);
		found = 1'b0;
		best  = '0;
		idx   = '0;
		for (int i = 0; i < task_total; i++) begin
			if (state_q[i] == ST_RUNNING && (!found || slice_q[i] > best)) begin
				found = 1'b1;
				best  = slice_q[i];
				idx   = TID_W'(i);
			end
		end
	endtask

	task automatic reschedule();
		logic             found;
		logic [CNT_W-1:0] best;
		logic [TID_W-1:0] idx;
		logic [CNT_W:0]   sum;
		pick_best(found, best, idx);
		if (found && best == '0) begin
			// recharge every entry, zombies included
			for (int i = 0; i < task_total; i++) begin
				sum = (CNT_W+1)'(slice_q[i] >> 1) + (CNT_W+1)'(prio_q[i]);
				slice_q[i] = (sum > (CNT_W+1)'(CNT_MAX)) ? CNT_MAX : sum[CNT_W-1:0];
			end
			pick_best(found, best, idx);
		end
		cur_q = idx;
	endtask

	task automatic schedule_request(kind_t k, logic [TID_W-1:0] tid, logic [PRIO_W-1:0] prio,
			logic [CNT_W-1:0] cnt);
		decision_t        d;
		logic [TID_W-1:0] prev;
		prev   = cur_q;
		d.aid  = '0;
		d.full = 1'b0;
		case (k)
			KIND_TICK: begin
				if (slice_q[cur_q] != '0)
					slice_q[cur_q] = slice_q[cur_q] - 1'b1;
				if (slice_q[cur_q] == '0)
					reschedule();
			end
			KIND_YIELD: begin
				slice_q[cur_q] = '0;
				reschedule();
			end
			KIND_ADD: begin
				if (task_total >= MAX_TASKS) begin
					d.full = 1'b1;
				end else begin
					slice_q[task_total] = cnt;
					prio_q[task_total]  = (prio == '0) ? PRIO_W'(1) : prio;
					state_q[task_total] = ST_RUNNING;
					d.aid = TID_W'(task_total);
					task_total++;
				end
			end
			default: begin
				if (int'(tid) < task_total)
					state_q[tid] = ST_ZOMBIE;
				slice_q[cur_q] = '0;
				reschedule();
			end
		endcase
		d.cur = cur_q;
		d.sw  = (cur_q != prev);
		decision_q.push_back(d);
	endtask

	always @(posedge clk or negedge arst_n) begin
		decision_t exp_d;
		if (!arst_n) begin
			for (int i = 0; i < MAX_TASKS; i++) begin
				slice_q[i] = '0;
				prio_q[i]  = '0;
				state_q[i] = ST_RUNNING;
			end
			prio_q[0]  = PRIO_IDLE;
			task_total = 1;
			cur_q      = '0;
			decision_q.delete();
			mismatches = 0;
			pending    = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (decision_q.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result with no request outstanding: cur=%0d sw=%0d id=%0d st=%0d",
							$realtime, current_task, switched, assigned_id, status);
					mismatches++;
				end else begin
					exp_d = decision_q.pop_front();
					if (current_task !== exp_d.cur || switched !== exp_d.sw ||
							assigned_id !== exp_d.aid || status !== exp_d.full) begin
						if (mismatches < 10)
							$display("%0t: mismatch: expected cur=%0d sw=%0d id=%0d st=%0d, got cur=%0d sw=%0d id=%0d st=%0d",
								$realtime, exp_d.cur, exp_d.sw, exp_d.aid, exp_d.full,
								current_task, switched, assigned_id, status);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall)
				schedule_request(kind_t'(kind), task_id, new_priority, start_counter);
			pending = decision_q.size();
		end
	end

endmodule

/* verif/tb_counter_priority_task_scheduler.sv */
// Testbench top for the task scheduler: clock, reset, request stimulus, receiver stalls, verdict.
module tb_counter_priority_task_scheduler;
	timeunit 1ns;
	timeprecision 1ps;
	import cpts_pkg::*;

	localparam int MAX_TASKS  = 16;
	localparam int RAND_ITEMS = 500;
	localparam int TAIL_ITEMS = 60;
	localparam int LIMIT      = 400000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [KIND_W-1:0] kind = '0;
	logic [TID_W-1:0]  task_id = '0;
	logic [PRIO_W-1:0] new_priority = '0;
	logic [CNT_W-1:0]  start_counter = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [TID_W-1:0]  current_task;
	logic              switched;
	logic [TID_W-1:0]  assigned_id;
	logic              status;
	int                mismatches;
	int                pending;

	int burst_left = 0;

	counter_priority_task_scheduler #(.MAX_TASKS(MAX_TASKS)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .task_id(task_id), .new_priority(new_priority),
		.start_counter(start_counter),
		.out_valid(out_valid), .out_stall(out_stall),
		.current_task(current_task), .switched(switched),
		.assigned_id(assigned_id), .status(status)
	);

	counter_priority_task_scheduler_chk #(.MAX_TASKS(MAX_TASKS)) sched_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .task_id(task_id), .new_priority(new_priority),
		.start_counter(start_counter),
		.out_valid(out_valid), .out_stall(out_stall),
		.current_task(current_task), .switched(switched),
		.assigned_id(assigned_id), .status(status),
		.mismatches(mismatches), .pending(pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic offer(kind_t k, logic [TID_W-1:0] t, logic [PRIO_W-1:0] p,
			logic [CNT_W-1:0] c);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 7) == 0) begin
				gap        = 0;
				burst_left = $urandom_range(50, 100);
			end else begin
				gap        = $urandom_range(1, 10);
				burst_left = $urandom_range(1, 16);
			end
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		kind          <= k;
		task_id       <= t;
		new_priority  <= p;
		start_counter <= c;
		in_valid      <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic random_request(bit tail);
		int               r;
		kind_t            k;
		logic [PRIO_W-1:0] p;
		logic [CNT_W-1:0]  c;
		r = $urandom_range(0, 99);
		if (!tail)
			k = (r < 59) ? KIND_TICK : (r < 79) ? KIND_YIELD : (r < 95) ? KIND_ADD : KIND_EXIT;
		else
			k = (r < 30) ? KIND_TICK : (r < 45) ? KIND_YIELD : (r < 50) ? KIND_ADD : KIND_EXIT;
		r = $urandom_range(0, 99);
		p = (r < 5) ? '0 : (r < 10) ? 8'd255 : PRIO_W'($urandom_range(1, 255));
		r = $urandom_range(0, 99);
		if (r < 40)
			c = CNT_W'($urandom_range(0, 7));
		else if (r < 60)
			c = CNT_W'($urandom_range(0, 63));
		else if (r < 70)
			c = CNT_MAX;
		else if (r < 75)
			c = '0;
		else
			c = CNT_W'($urandom_range(0, 1023));
		offer(k, TID_W'($urandom_range(0, 15)), p, c);
	endtask

	// receiver: shifting stall patterns plus one long hold-off
	initial begin
		int  mode;
		int  mode_left;
		int  hold_left;
		int  cyc;
		mode_left = 0;
		hold_left = 0;
		cyc       = 0;
		mode      = 0;
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc == 2500)
				hold_left = 300;
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(10, 80);
				end
				mode_left--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ~out_stall;
				endcase
			end
		end
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("** counter_priority_task_scheduler: FAILED **");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed requests
		offer(KIND_TICK,  4'd0,  8'd0,   10'd0);
		offer(KIND_TICK,  4'd0,  8'd0,   10'd0);
		offer(KIND_ADD,   4'd0,  8'd0,   10'd0);
		offer(KIND_ADD,   4'd0,  8'd255, 10'd1023);
		offer(KIND_ADD,   4'd0,  8'd128, 10'd512);
		offer(KIND_YIELD, 4'd0,  8'd0,   10'd0);
		offer(KIND_TICK,  4'd0,  8'd0,   10'd0);
		offer(KIND_EXIT,  4'd15, 8'd0,   10'd0);
		offer(KIND_EXIT,  4'd3,  8'd0,   10'd0);
		offer(KIND_ADD,   4'd0,  8'd1,   10'd1);
		offer(KIND_TICK,  4'd0,  8'd0,   10'd0);
		offer(KIND_TICK,  4'd0,  8'd0,   10'd0);
		offer(KIND_TICK,  4'd0,  8'd0,   10'd0);
		offer(KIND_YIELD, 4'd0,  8'd0,   10'd0);
		offer(KIND_ADD,   4'd5,  8'h55,  10'h2aa);
		offer(KIND_ADD,   4'd10, 8'haa,  10'h155);
		offer(KIND_EXIT,  4'd4,  8'd0,   10'd0);
		offer(KIND_YIELD, 4'd0,  8'd0,   10'd0);
		offer(KIND_TICK,  4'd0,  8'd0,   10'd0);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n == 300) begin
				@(negedge clk);
				in_valid <= 1'b0;
				while (pending != 0) @(negedge clk);
			end
			random_request(n >= RAND_ITEMS - TAIL_ITEMS);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("** counter_priority_task_scheduler: PASSED **");
		else
			$display("** counter_priority_task_scheduler: FAILED **");
		$finish;
	end

endmodule

/* counter_priority_task_scheduler.f */
rtl/cpts_pkg.sv
rtl/cpts_cell.sv
rtl/cpts_ctrl.sv
rtl/counter_priority_task_scheduler.sv
verif/counter_priority_task_scheduler_chk.sv
verif/tb_counter_priority_task_scheduler.sv
